[hw/rtl/vfcm_pkg.sv]
`default_nettype none

package vfcm_pkg;

  // Default geometry of the chunk and width of a stored id.
  localparam int CHUNK_SIDE_DEF = 16;
  localparam int CHUNK_ROWS_DEF = 256;
  localparam int ID_BITS_DEF    = 8;

  // Depth of the queue between the classifier and the vertex emitter.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_X_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_Z_OFFSET  = 2'd1;
  localparam logic [1:0] CFG_TOP_LIMIT = 2'd2;

  // Request operation codes.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_MESH  = 1'b1;

  // Order of the seven store reads of a mesh request. Slots one to six follow
  // the face order, so face f sits in read slot f + 1.
  localparam logic [2:0] RD_CENTER = 3'd0;
  localparam logic [2:0] RD_FRONT  = 3'd1;
  localparam logic [2:0] RD_BACK   = 3'd2;
  localparam logic [2:0] RD_RIGHT  = 3'd3;
  localparam logic [2:0] RD_LEFT   = 3'd4;
  localparam logic [2:0] RD_TOP    = 3'd5;
  localparam logic [2:0] RD_BOTTOM = 3'd6;

  typedef enum logic [2:0] {
    F_CLEAR,
    F_IDLE,
    F_EXEC,
    F_READ,
    F_DRAIN,
    F_PUSH
  } front_state_e;

  // One classified voxel: its chunk position, id and the set of visible faces
  // (bit f set means face f is drawn).
  typedef struct packed {
    logic [5:0] x;
    logic [7:0] y;
    logic [5:0] z;
    logic [7:0] id;
    logic [5:0] mask;
  } job_t;

endpackage

`default_nettype wire

[hw/rtl/vfcm_front.sv]
`default_nettype none

module vfcm_front
  import vfcm_pkg::*;
#(
  parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
  parameter int CHUNK_ROWS = CHUNK_ROWS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire logic       req_op_i,
  input  wire logic [5:0] req_x_i,
  input  wire logic [7:0] req_y_i,
  input  wire logic [5:0] req_z_i,
  input  wire logic [7:0] req_id_i,
  input  wire logic [7:0] top_limit_i,
  output logic            job_valid_o,
  input  wire logic       job_ready_i,
  output job_t            job_o
);

  localparam int PAD   = CHUNK_SIDE + 2;
  localparam int PAD2  = PAD * PAD;
  localparam int DEPTH = PAD2 * CHUNK_ROWS;
  localparam int AW    = $clog2(DEPTH);

  function automatic int rd_offset(logic [2:0] k);
    int off;
    off = 0;
    case (k)
      RD_FRONT:  off = -PAD;
      RD_BACK:   off = PAD;
      RD_RIGHT:  off = 1;
      RD_LEFT:   off = -1;
      RD_TOP:    off = PAD2;
      RD_BOTTOM: off = -PAD2;
      default:   off = 0;
    endcase
    return off;
  endfunction

  front_state_e state_q, state_d;
  logic [2:0]    k_q, k_d;
  logic          rsp_vld_q, rsp_vld_d;
  logic [2:0]    rsp_k_q;
  logic [AW-1:0] clr_q, clr_d;

  logic          op_q;
  logic [5:0]    x_q, z_q;
  logic [7:0]    y_q, vid_q;
  logic [AW-1:0] addr_q, addr_d;
  logic [ID_BITS-1:0] id_q;
  logic [5:0]    mask_q;

  logic [ID_BITS-1:0] store_q [DEPTH];
  logic [ID_BITS-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [ID_BITS-1:0] mem_wdata;

  logic               accept;
  logic               wr_in_range, mesh_ok, clr_done, job_has_faces;
  logic [ID_BITS+7:0] vid_ext;
  logic [ID_BITS+7:0] id_ext;
  logic               force_empty;
  int                 xs, zs, ys;

  assign xs = int'($signed(x_q));
  assign zs = int'($signed(z_q));
  assign ys = int'(y_q);

  assign wr_in_range = (xs >= -1) && (xs <= CHUNK_SIDE) && (zs >= -1) &&
                       (zs <= CHUNK_SIDE) && (ys < CHUNK_ROWS);
  assign mesh_ok = (xs >= 0) && (xs < CHUNK_SIDE) && (zs >= 0) &&
                   (zs < CHUNK_SIDE) && (ys < CHUNK_ROWS) && (y_q <= top_limit_i);
  assign clr_done      = (clr_q == AW'(DEPTH - 1));
  assign job_has_faces = (id_q != '0) && (mask_q != 6'd0);
  assign accept        = req_valid_i && req_ready_o;

  assign vid_ext = {{ID_BITS{1'b0}}, vid_q};
  assign id_ext  = {8'd0, id_q};

  assign addr_d = AW'((int'($signed(req_x_i)) + 1) + (int'($signed(req_z_i)) + 1) * PAD +
                      int'(req_y_i) * PAD2);

  // Rows outside the chunk count as empty neighbors.
  assign force_empty = ((rsp_k_q == RD_TOP) && (ys == CHUNK_ROWS - 1)) ||
                       ((rsp_k_q == RD_BOTTOM) && (y_q == 8'd0));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_CLEAR: if (clr_done) state_d = F_IDLE;
      F_IDLE:  if (req_valid_i) state_d = F_EXEC;
      F_EXEC: begin
        if (op_q == OP_MESH && mesh_ok) state_d = F_READ;
        else state_d = F_IDLE;
      end
      F_READ:  if (k_q == RD_BOTTOM) state_d = F_DRAIN;
      F_DRAIN: state_d = F_PUSH;
      F_PUSH:  if (!job_has_faces || job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    job_valid_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = addr_q;
    mem_wdata   = vid_ext[ID_BITS-1:0];
    k_d         = k_q;
    clr_d       = clr_q;
    rsp_vld_d   = 1'b0;
    unique case (state_q)
      F_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
      end
      F_IDLE: begin
        req_ready_o = 1'b1;
        k_d         = RD_CENTER;
      end
      F_EXEC: begin
        mem_we = (op_q == OP_STORE) && wr_in_range;
      end
      F_READ: begin
        mem_re    = 1'b1;
        mem_addr  = AW'(int'(addr_q) + rd_offset(k_q));
        rsp_vld_d = 1'b1;
        k_d       = k_q + 3'd1;
      end
      F_DRAIN: ;
      F_PUSH: begin
        job_valid_o = job_has_faces;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_CLEAR;
      k_q       <= RD_CENTER;
      rsp_vld_q <= 1'b0;
      rsp_k_q   <= RD_CENTER;
      clr_q     <= '0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      rsp_vld_q <= rsp_vld_d;
      rsp_k_q   <= k_q;
      clr_q     <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_op_i;
      x_q    <= req_x_i;
      y_q    <= req_y_i;
      z_q    <= req_z_i;
      vid_q  <= req_id_i;
      addr_q <= addr_d;
    end
    if (rsp_vld_q) begin
      if (rsp_k_q == RD_CENTER) id_q <= rdata_q;
      else mask_q[rsp_k_q - 3'd1] <= force_empty || (rdata_q == '0);
    end
  end

  // Single-port voxel store with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_addr] <= mem_wdata;
    else if (mem_re) rdata_q <= store_q[mem_addr];
  end

  assign job_o.x    = x_q;
  assign job_o.y    = y_q;
  assign job_o.z    = z_q;
  assign job_o.id   = id_ext[7:0];
  assign job_o.mask = mask_q;

endmodule

`default_nettype wire

[hw/rtl/vfcm_queue.sv]
`default_nettype none

module vfcm_queue
  import vfcm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire job_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

[hw/rtl/vfcm_back.sv]
`default_nettype none

module vfcm_back
  import vfcm_pkg::*;
#(
  parameter int CHUNK_SIDE = CHUNK_SIDE_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  input  wire job_t               job_i,
  input  wire logic signed [11:0] x_off_i,
  input  wire logic signed [11:0] z_off_i,
  output logic                    vtx_valid_o,
  input  wire logic               vtx_ready_i,
  output logic [55:0]             vtx_data_o,
  output logic                    vtx_last_o
);

  // Corner table, four corners per face: {dx, dy, dz, u, v}.
  localparam logic [4:0] CORNER_TBL [24] = '{
    5'b00000, 5'b01001, 5'b11011, 5'b10010,
    5'b10100, 5'b11101, 5'b01111, 5'b00110,
    5'b10000, 5'b11001, 5'b11111, 5'b10110,
    5'b00100, 5'b01101, 5'b01011, 5'b00010,
    5'b01000, 5'b01101, 5'b11111, 5'b11010,
    5'b00100, 5'b00001, 5'b10011, 5'b10110
  };

  function automatic logic [2:0] lowest_face(logic [5:0] m);
    logic [2:0] f;
    f = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (m[i]) f = 3'(i);
    end
    return f;
  endfunction

  logic        busy_q, busy_d;
  logic [5:0]  rem_q, rem_d;
  logic [1:0]  c_q;
  logic [7:0]  y_q, id_q;
  logic [16:0] base_x_q, base_z_q;
  logic        ovld_q, ovld_d;
  logic [55:0] odata_q;
  logic        olast_q;

  logic        load, adv;
  logic [2:0]  cur_f;
  logic [4:0]  corner;
  logic [16:0] wx, wz;
  logic [8:0]  wy;
  logic        last_vtx;

  assign job_ready_o = !busy_q;
  assign load        = job_valid_i && !busy_q;
  assign adv         = busy_q && (!ovld_q || vtx_ready_i);
  assign cur_f       = lowest_face(rem_q);
  assign corner      = CORNER_TBL[{cur_f, c_q}];

  assign wx = base_x_q + {16'd0, corner[4]};
  assign wy = {1'b0, y_q} + {8'd0, corner[3]};
  assign wz = base_z_q + {16'd0, corner[2]};

  always_comb begin
    rem_d = rem_q;
    if (c_q == 2'd3) rem_d[cur_f] = 1'b0;
  end

  assign last_vtx = (c_q == 2'd3) && (rem_d == 6'd0);

  always_comb begin
    busy_d = busy_q;
    ovld_d = ovld_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (adv && last_vtx) begin
      busy_d = 1'b0;
    end
    if (adv) ovld_d = 1'b1;
    else if (vtx_ready_i) ovld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
      rem_q  <= 6'd0;
      c_q    <= 2'd0;
    end else begin
      busy_q <= busy_d;
      ovld_q <= ovld_d;
      if (load) begin
        rem_q <= job_i.mask;
        c_q   <= 2'd0;
      end else if (adv) begin
        rem_q <= rem_d;
        c_q   <= c_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      y_q      <= job_i.y;
      id_q     <= job_i.id;
      base_x_q <= 17'(int'($signed(job_i.x)) + int'(x_off_i) * CHUNK_SIDE);
      base_z_q <= 17'(int'($signed(job_i.z)) + int'(z_off_i) * CHUNK_SIDE);
    end
    if (adv) begin
      odata_q <= {cur_f, id_q, corner[0], corner[1], wz, wy, wx};
      olast_q <= last_vtx;
    end
  end

  assign vtx_valid_o = ovld_q;
  assign vtx_data_o  = odata_q;
  assign vtx_last_o  = olast_q;

endmodule

`default_nettype wire

[hw/rtl/voxel_face_culling_mesher.sv]
// Voxel face-culling mesher for one chunk.
// Requests arrive on the s_axis channel. tuser selects the operation: a store
// request writes a block id into the padded voxel store and produces nothing;
// a mesh request names one voxel and, if its id is not zero, produces four
// vertices on m_axis for each of its faces whose neighbor is empty, in front,
// back, right, left, top, bottom order. tlast marks the final vertex of a request.
// The classifier takes one request at a time: a store request, or a mesh request
// outside the chunk or above the row limit, is accepted and decoded and then
// frees the input; any other mesh request goes through accept, decode, seven
// reads of the single-port voxel store, a wait for the last read data and, if
// it has a visible face, the hand-off to the queue, which waits while it is full.
// Vertices leave at one per cycle from an output register while m_axis_tready
// is high; the emitter loads the next request only after the last vertex of
// the previous one has left it. A two-entry queue between classifier and
// emitter lets the next request be read while earlier vertices are still leaving.
// When m_axis stalls, the output register, the emitter and the queue fill in turn
// and finally s_axis_tready stays low.
// After reset the store is cleared one entry a cycle, all (CHUNK_SIDE+2)^2 *
// CHUNK_ROWS entries (82944 with the default geometry); s_axis_tready stays
// low meanwhile. Configuration writes are taken at any time, but should only
// be made while the block is idle.
`default_nettype none

module voxel_face_culling_mesher
  import vfcm_pkg::*;
#(
  parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
  parameter int CHUNK_ROWS = CHUNK_ROWS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_wdata_i,
  // Request channel.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: x_pos[5:0], y_pos[13:6], z_pos[19:14], voxel_id[27:20],
  // zero fill [31:28].
  input  wire logic [31:0] s_axis_tdata,
  // tuser: operation.
  input  wire logic        s_axis_tuser,
  // Vertex channel.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: world_x[16:0], world_y[25:17], world_z[42:26],
  // tex_u[43], tex_v[44], block_id[52:45], face_index[55:53].
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  logic signed [11:0] x_off_q;
  logic signed [11:0] z_off_q;
  logic [7:0]         top_limit_q;

  // Register writes land directly; there is no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q     <= 12'sd0;
      z_off_q     <= 12'sd0;
      top_limit_q <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_OFFSET:  x_off_q     <= $signed(cfg_wdata_i);
        CFG_Z_OFFSET:  z_off_q     <= $signed(cfg_wdata_i);
        CFG_TOP_LIMIT: top_limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic job_push_valid, job_push_ready;
  logic job_pop_valid, job_pop_ready;
  job_t job_push, job_pop;

  // Front: accepts requests, owns the voxel store and classifies faces.
  vfcm_front #(
    .CHUNK_SIDE(CHUNK_SIDE),
    .CHUNK_ROWS(CHUNK_ROWS),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_op_i   (s_axis_tuser),
    .req_x_i    (s_axis_tdata[5:0]),
    .req_y_i    (s_axis_tdata[13:6]),
    .req_z_i    (s_axis_tdata[19:14]),
    .req_id_i   (s_axis_tdata[27:20]),
    .top_limit_i(top_limit_q),
    .job_valid_o(job_push_valid),
    .job_ready_i(job_push_ready),
    .job_o      (job_push)
  );

  // Queue of classified voxels waiting for vertex emission.
  vfcm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(job_push_valid),
    .push_ready_o(job_push_ready),
    .push_data_i (job_push),
    .pop_valid_o (job_pop_valid),
    .pop_ready_i (job_pop_ready),
    .pop_data_o  (job_pop)
  );

  // Back: walks the visible faces and emits one vertex a cycle while m_axis is ready.
  vfcm_back #(
    .CHUNK_SIDE(CHUNK_SIDE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_pop_valid),
    .job_ready_o(job_pop_ready),
    .job_i      (job_pop),
    .x_off_i    (x_off_q),
    .z_off_i    (z_off_q),
    .vtx_valid_o(m_axis_tvalid),
    .vtx_ready_i(m_axis_tready),
    .vtx_data_o (m_axis_tdata),
    .vtx_last_o (m_axis_tlast)
  );

endmodule

`default_nettype wire
